// File: hdl/hc2_pkg.sv
// Shared types, constants and helper functions for the 2x2 Hill cipher stream unit.
// No dependencies; every other file imports this package.
package hc2_pkg;

	localparam int unsigned LetterW = 5;
	localparam int unsigned CharW   = 8;
	localparam int unsigned OutW    = 7;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 5;

	localparam logic [LetterW-1:0] ALPHA      = 5'd26;
	localparam logic [LetterW-1:0] PAD_LETTER = 5'd23;   // 'X'
	localparam logic [OutW-1:0]    ASCII_A    = 7'd65;
	localparam logic [CharW-1:0]   UPPER_A    = 8'd65;
	localparam logic [CharW-1:0]   UPPER_Z    = 8'd90;
	localparam logic [CharW-1:0]   LOWER_A    = 8'd97;
	localparam logic [CharW-1:0]   LOWER_Z    = 8'd122;
	localparam logic [OutW-1:0]    ERR_CHAR   = 7'd0;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_KEY_A     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_B     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_C     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_D     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DIRECTION = 3'd4;

	// one completed pair waiting for the arithmetic back end
	typedef struct packed {
		logic [LetterW-1:0] p1;
		logic [LetterW-1:0] p2;
		logic               endf;
	} job_t;

	// working matrix (key or inverse key) and the singular-key flag
	typedef struct packed {
		logic [LetterW-1:0] m00;
		logic [LetterW-1:0] m01;
		logic [LetterW-1:0] m10;
		logic [LetterW-1:0] m11;
		logic               kerr;
	} key_t;

	// reduce a 5-bit residue candidate into 0..25
	function automatic logic [LetterW-1:0] red26(input logic [LetterW-1:0] v);
		logic [LetterW-1:0] r;
		r = (v >= ALPHA) ? (v - ALPHA) : v;
		return r;
	endfunction

	// x mod 26 for x below 4096: reciprocal estimate, then one correction
	function automatic logic [LetterW-1:0] mod26(input logic [11:0] x);
		logic [20:0] prod;
		logic [7:0]  q;
		logic [11:0] r;
		prod = {9'd0, x} * 21'd315;
		q    = prod[20:13];
		r    = x - {4'd0, q} * 12'd26;
		if (r >= 12'd26) begin
			r = r - 12'd26;
		end
		return r[LetterW-1:0];
	endfunction

	// inverse of a residue mod 26; zero where none exists
	function automatic logic [LetterW-1:0] unit_inv(input logic [LetterW-1:0] v);
		logic [LetterW-1:0] r;
		case (v)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/hc2_if.sv
// Valid/ready channel interfaces: character input, result output, configuration writes.
// Depends on hc2_pkg for field widths.
interface hc2_in_if import hc2_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CharW-1:0]   in_char;
	logic               message_end;
	modport source (output valid, in_char, message_end, input ready);
	modport sink   (input valid, in_char, message_end, output ready);
endinterface

interface hc2_out_if import hc2_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OutW-1:0]    out_char;
	logic               pair_second;
	logic               key_error;
	logic               end_out;
	modport source (output valid, out_char, pair_second, key_error, end_out, input ready);
	modport sink   (input valid, out_char, pair_second, key_error, end_out, output ready);
endinterface

interface hc2_cfg_if import hc2_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/hill_cipher_2x2_stream_unit.sv
// 2x2 Hill cipher (mod 26) over a character stream, one byte per input item. Non-letters are
// dropped, letters are upper-cased and paired; each pair gives two result letters (K*P when
// encrypting, inverse key when decrypting), or one error item when decrypting with a singular
// key. An item flagged message_end pads a pending letter with X. Timing: the front end takes
// one input item per cycle while its two-entry pair queue has room; the back end drives the
// single output register one result item at a time and holds each pair until its last item
// is out (only the error item on a key error). After every configuration write the back end
// starts no new pair until the key setup pipeline has settled; items are still taken during
// that time. Configuration writes are always ready.
// Depends on hc2_pkg, hc2_if, hc2_front, hc2_key, hc2_back.
module hill_cipher_2x2_stream_unit import hc2_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hc2_in_if.sink    in_ch,
	hc2_out_if.source out_ch,
	hc2_cfg_if.sink   cfg
);

	// configuration registers, raw as written
	logic [LetterW-1:0] key_a_q, key_b_q, key_c_q, key_d_q;
	logic               direction_q;
	// cycles left until the key pipeline reflects the last write
	logic [1:0]         settle_q;

	logic               cfg_wr;
	logic               job_valid;
	logic               job_pop;
	job_t               job;
	key_t               key;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// register bank: writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q     <= 5'd1;
			key_b_q     <= 5'd0;
			key_c_q     <= 5'd0;
			key_d_q     <= 5'd1;
			direction_q <= 1'b0;
			settle_q    <= 2'd3;
		end else begin
			if (cfg_wr) begin
				case (cfg.index)
					REG_KEY_A:     key_a_q     <= cfg.data;
					REG_KEY_B:     key_b_q     <= cfg.data;
					REG_KEY_C:     key_c_q     <= cfg.data;
					REG_KEY_D:     key_d_q     <= cfg.data;
					REG_DIRECTION: direction_q <= cfg.data[0];
					default:       ;
				endcase
			end
			// restart the settle window on any write, else count down
			if (cfg_wr) begin
				settle_q <= 2'd3;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// front: filter, pair and queue
	hc2_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// key setup: reduced key or inverse key, plus singular flag
	hc2_key u_key (
		.clk       (clk),
		.key_a     (key_a_q),
		.key_b     (key_b_q),
		.key_c     (key_c_q),
		.key_d     (key_d_q),
		.direction (direction_q),
		.key       (key)
	);

	// back: multiply, reduce and hand out letters one per cycle while the output accepts them
	hc2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.key       (key),
		.key_busy  (settle_q != 2'd0),
		.out_ch    (out_ch)
	);

endmodule

// File: hdl/hc2_front.sv
// Front end: accepts characters, filters and pairs letters, queues completed pairs.
// Depends on hc2_pkg and hc2_in_if.
module hc2_front import hc2_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hc2_in_if.sink       in_ch,
	output logic         job_valid,
	output job_t         job,
	input  logic         job_pop
);

	logic [LetterW-1:0] held_letter_q;
	logic               held_valid_q;
	job_t               fifo_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	logic               accept;
	logic               is_letter;
	logic [LetterW-1:0] letter;
	logic               push;
	job_t               push_job;
	logic [CharW-1:0]   ofs;

	always_comb begin
		ofs       = '0;
		is_letter = 1'b0;
		if (in_ch.in_char >= UPPER_A && in_ch.in_char <= UPPER_Z) begin
			is_letter = 1'b1;
			ofs       = in_ch.in_char - UPPER_A;
		end else if (in_ch.in_char >= LOWER_A && in_ch.in_char <= LOWER_Z) begin
			is_letter = 1'b1;
			ofs       = in_ch.in_char - LOWER_A;
		end
		letter = ofs[LetterW-1:0];
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		push          = 1'b0;
		push_job.p1   = held_letter_q;
		push_job.p2   = letter;
		push_job.endf = in_ch.message_end;
		if (accept) begin
			if (is_letter && held_valid_q) begin
				push = 1'b1;
			end else if (is_letter && in_ch.message_end) begin
				push        = 1'b1;
				push_job.p1 = letter;
				push_job.p2 = PAD_LETTER;
			end else if (!is_letter && in_ch.message_end && held_valid_q) begin
				push        = 1'b1;
				push_job.p2 = PAD_LETTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			count_q      <= 2'd0;
		end else begin
			if (accept) begin
				if (push) begin
					held_valid_q <= 1'b0;
				end else if (is_letter) begin
					held_valid_q <= 1'b1;
				end
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, job_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_letter && !push) begin
			held_letter_q <= letter;
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= push_job;
		end
	end

	assign job_valid = (count_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];

endmodule

// File: hdl/hc2_key.sv
// Key setup pipeline: reduces the key, forms the inverse matrix for decrypt, flags singular keys.
// Depends on hc2_pkg.
module hc2_key import hc2_pkg::*; (
	input  logic               clk,
	input  logic [LetterW-1:0] key_a,
	input  logic [LetterW-1:0] key_b,
	input  logic [LetterW-1:0] key_c,
	input  logic [LetterW-1:0] key_d,
	input  logic               direction,
	output key_t               key
);

	logic [LetterW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic [9:0]         ad_s1, bc_s1;
	logic               dir_s1;
	logic [LetterW-1:0] a_s2, b_s2, c_s2, d_s2, nb_s2, nc_s2, inv_s2;
	logic               dir_s2;
	key_t               key_s3;

	logic [LetterW-1:0] ra, rb, rc, rd;

	assign ra = red26(key_a);
	assign rb = red26(key_b);
	assign rc = red26(key_c);
	assign rd = red26(key_d);

	always_ff @(posedge clk) begin
		a_s1   <= ra;
		b_s1   <= rb;
		c_s1   <= rc;
		d_s1   <= rd;
		ad_s1  <= ra * rd;
		bc_s1  <= rb * rc;
		dir_s1 <= direction;

		a_s2   <= a_s1;
		b_s2   <= b_s1;
		c_s2   <= c_s1;
		d_s2   <= d_s1;
		nb_s2  <= (b_s1 == '0) ? '0 : (ALPHA - b_s1);
		nc_s2  <= (c_s1 == '0) ? '0 : (ALPHA - c_s1);
		inv_s2 <= unit_inv(mod26({2'b00, ad_s1} + 12'd676 - {2'b00, bc_s1}));
		dir_s2 <= dir_s1;

		if (dir_s2) begin
			key_s3.m00  <= mod26({7'd0, inv_s2} * {7'd0, d_s2});
			key_s3.m01  <= mod26({7'd0, inv_s2} * {7'd0, nb_s2});
			key_s3.m10  <= mod26({7'd0, inv_s2} * {7'd0, nc_s2});
			key_s3.m11  <= mod26({7'd0, inv_s2} * {7'd0, a_s2});
			key_s3.kerr <= (inv_s2 == '0);
		end else begin
			key_s3.m00  <= a_s2;
			key_s3.m01  <= b_s2;
			key_s3.m10  <= c_s2;
			key_s3.m11  <= d_s2;
			key_s3.kerr <= 1'b0;
		end
	end

	assign key = key_s3;

endmodule

// File: hdl/hc2_back.sv
// Back end: takes queued pairs, forms the matrix products and serializes the result letters.
// Depends on hc2_pkg and hc2_out_if.
module hc2_back import hc2_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	input  job_t         job,
	output logic         job_pop,
	input  key_t         key,
	input  logic         key_busy,
	hc2_out_if.source    out_ch
);

	logic        v_s1;
	logic [10:0] sum1_s1, sum2_s1;
	logic        endf_s1;
	logic        kerr_s1;
	logic        phase_q;

	logic        out_v_q;
	logic [OutW-1:0] out_char_q;
	logic        pair_second_q, key_error_q, end_out_q;

	logic        emit, done, load;

	assign emit    = v_s1 && (!out_v_q || out_ch.ready);
	assign done    = emit && (kerr_s1 || phase_q);
	assign load    = job_valid && !key_busy && (!v_s1 || done);
	assign job_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			phase_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (done) begin
				v_s1 <= 1'b0;
			end
			if (done) begin
				phase_q <= 1'b0;
			end else if (emit) begin
				phase_q <= 1'b1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum1_s1 <= {6'd0, key.m00} * {6'd0, job.p1} + {6'd0, key.m01} * {6'd0, job.p2};
			sum2_s1 <= {6'd0, key.m10} * {6'd0, job.p1} + {6'd0, key.m11} * {6'd0, job.p2};
			endf_s1 <= job.endf;
			kerr_s1 <= key.kerr;
		end
		if (emit) begin
			end_out_q <= endf_s1;
			if (kerr_s1) begin
				out_char_q    <= ERR_CHAR;
				pair_second_q <= 1'b1;
				key_error_q   <= 1'b1;
			end else if (phase_q) begin
				out_char_q    <= ASCII_A + OutW'(mod26({1'b0, sum2_s1}));
				pair_second_q <= 1'b1;
				key_error_q   <= 1'b0;
			end else begin
				out_char_q    <= ASCII_A + OutW'(mod26({1'b0, sum1_s1}));
				pair_second_q <= 1'b0;
				key_error_q   <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.out_char    = out_char_q;
	assign out_ch.pair_second = pair_second_q;
	assign out_ch.key_error   = key_error_q;
	assign out_ch.end_out     = end_out_q;

endmodule
